/* design/preorder_forest_stream_validator_defines.svh */
// Assertion macros used by the checker file of the preorder forest validator.
`ifndef PREORDER_FOREST_STREAM_VALIDATOR_DEFINES_SVH
`define PREORDER_FOREST_STREAM_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PFSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PFSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pfsv_pkg.sv */
// Package with the types, codes and default sizes of the preorder forest validator.
package pfsv_pkg;

  localparam int unsigned MAX_NODES_DEF = 4096;
  localparam int unsigned MAX_DEPTH_DEF = 16;

  localparam logic [31:0] ROOT_MARK = 32'hFFFF_FFFF;

  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_NODE   = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_DEPTH   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_SCAN,
    ST_POST,
    ST_WR_PAR,
    ST_WR_TOP,
    ST_EMIT
  } pfsv_state_t;

endpackage

/* design/pfsv_stack.sv */
// Ancestor stack memory: one write port and one registered read port.
module pfsv_stack #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 26
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DW-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DW-1:0]                          rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/preorder_forest_stream_validator.sv */
// Top level of the preorder forest validator: sequencer, ancestor search and result register.
//
// The block checks a forest that arrives in preorder, one input word at a time.
// A header word (in_func 0) announces the node count and starts a new record; a
// node word (in_func 1) carries its index, parent index, sibling position and
// two signed shot counts. Every input word gives exactly one result word with
// the sticky status, the depth of the accepted node and the record-done flag.
// Both channels use valid/ready. in_ready is high only while the sequencer is
// idle, so one word is worked on at a time. A header goes from accept straight
// to the result. A root node passes the index check, the final checks and the
// stack write. A child node also searches the ancestor stack from the bottom
// entry up to its parent, one entry per cycle through the single read port
// of the stack memory, and then writes back both its parent and itself.
// A rejected node leaves as soon as its failing check is seen.
// The result sits in an output register; when the receiver stalls the word is
// held there unchanged, and the sequencer waits with the next result until the
// register is free. Reset clears the counters, the error code and the stack
// level; the stack memory itself is not cleared, since an entry is only read
// after it has been written.
module preorder_forest_stream_validator #(
  parameter int unsigned MAX_NODES = pfsv_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_DEPTH = pfsv_pkg::MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [31:0]        in_node_count,
  input  logic [31:0]        in_node_index,
  input  logic [31:0]        in_parent_ref,
  input  logic [31:0]        in_sibling_pos,
  input  logic signed [15:0] in_shots_max,
  input  logic signed [15:0] in_shots_now,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [4:0]         out_node_depth,
  output logic               out_record_done
);
  import pfsv_pkg::*;

  // Counter width holds 0..MAX_NODES; the stack address covers MAX_DEPTH entries;
  // the depth width holds 0..MAX_DEPTH+1 so an over-deep node can still be seen.
  localparam int unsigned NW   = $clog2(MAX_NODES + 1);
  localparam int unsigned AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned DEPW = $clog2(MAX_DEPTH + 2);

  pfsv_state_t state_r, state_nxt;

  // Control state.
  logic [1:0]      err_r, err_nxt;
  logic [DEPW-1:0] level_r, level_nxt;
  logic [NW-1:0]   roots_r, roots_nxt;
  logic [NW-1:0]   next_r, next_nxt;
  logic [NW-1:0]   ann_r, ann_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Working registers of the item in flight.
  logic [DEPW-1:0]    pos_r, pos_nxt;
  logic [DEPW-1:0]    dep_r, dep_nxt;
  logic [NW-1:0]      exp_r, exp_nxt;
  logic [31:0]        idx_r, par_r, sib_r;
  logic signed [15:0] smax_r, snow_r;
  logic [1:0]         out_status_r;
  logic [4:0]         out_depth_r;
  logic               out_done_r;

  // Stack memory port.
  logic            st_we;
  logic [AW-1:0]   st_waddr, st_raddr;
  logic [2*NW-1:0] st_wdata, st_rdata;
  logic [NW-1:0]   rd_node, rd_children;

  logic            accept, out_free, is_root;
  logic            pre_bad, order_bad, scan_end, scan_hit;
  logic            sib_bad, dep_bad, shot_bad, post_bad;
  logic [DEPW-1:0] pos_inc, dep_dec;

  pfsv_stack #(
    .DEPTH (MAX_DEPTH),
    .DW    (2 * NW)
  ) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign rd_node     = st_rdata[2*NW-1:NW];
  assign rd_children = st_rdata[NW-1:0];

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign pos_inc = pos_r + DEPW'(1);
  assign dep_dec = dep_r - DEPW'(1);

  // Checks on the captured node word. The index must be the next one and the
  // record must still have room; a child must name a parent below itself.
  assign is_root   = (par_r == ROOT_MARK);
  assign pre_bad   = (next_r >= ann_r) || (idx_r != 32'(next_r));
  assign order_bad = (par_r >= idx_r);

  // The search compares one stack entry per cycle; the entry at pos_r is in
  // the read register while the sequencer sits in ST_SCAN.
  assign scan_end = (pos_r >= level_r);
  assign scan_hit = (par_r == 32'(rd_node));

  // Final checks in their fixed priority: sibling, depth, shot count.
  assign sib_bad  = (sib_r != 32'(exp_r));
  assign dep_bad  = (dep_r > DEPW'(MAX_DEPTH));
  assign shot_bad = (snow_r > smax_r);
  assign post_bad = sib_bad || dep_bad || shot_bad;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_HEADER || err_r != STAT_OK) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_PRE;
          end
        end
      end
      ST_PRE: begin
        if (pre_bad) begin
          state_nxt = ST_EMIT;
        end else if (is_root) begin
          state_nxt = ST_POST;
        end else if (order_bad) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_EMIT;
        end else if (scan_hit) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (post_bad) begin
          state_nxt = ST_EMIT;
        end else if (is_root) begin
          state_nxt = ST_WR_TOP;
        end else begin
          state_nxt = ST_WR_PAR;
        end
      end
      ST_WR_PAR: state_nxt = ST_WR_TOP;
      ST_WR_TOP: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    err_nxt   = err_r;
    level_nxt = level_r;
    roots_nxt = roots_r;
    next_nxt  = next_r;
    ann_nxt   = ann_r;
    pos_nxt   = pos_r;
    dep_nxt   = dep_r;
    exp_nxt   = exp_r;
    st_we     = 1'b0;
    st_waddr  = dep_dec[AW-1:0];
    st_wdata  = {idx_r[NW-1:0], {NW{1'b0}}};
    st_raddr  = pos_r[AW-1:0];
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        dep_nxt = '0;
        if (accept && in_func == FUNC_HEADER) begin
          level_nxt = '0;
          roots_nxt = '0;
          next_nxt  = '0;
          if (in_node_count > 32'(MAX_NODES)) begin
            err_nxt = STAT_INVALID;
            ann_nxt = '0;
          end else begin
            err_nxt = STAT_OK;
            ann_nxt = NW'(in_node_count);
          end
        end
      end
      ST_PRE: begin
        pos_nxt  = '0;
        st_raddr = '0;
        exp_nxt  = roots_r;
        dep_nxt  = DEPW'(1);
        if (pre_bad || (!is_root && order_bad)) begin
          err_nxt = STAT_INVALID;
          dep_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          err_nxt = STAT_INVALID;
          dep_nxt = '0;
        end else if (scan_hit) begin
          exp_nxt = rd_children;
          dep_nxt = pos_r + DEPW'(2);
        end else begin
          pos_nxt  = pos_inc;
          st_raddr = pos_inc[AW-1:0];
        end
      end
      ST_POST: begin
        if (sib_bad) begin
          err_nxt = STAT_INVALID;
          dep_nxt = '0;
        end else if (dep_bad) begin
          err_nxt = STAT_DEPTH;
          dep_nxt = '0;
        end else if (shot_bad) begin
          err_nxt = STAT_INVALID;
          dep_nxt = '0;
        end else begin
          next_nxt  = next_r + NW'(1);
          level_nxt = dep_r;
          if (is_root) begin
            roots_nxt = roots_r + NW'(1);
          end
        end
      end
      ST_WR_PAR: begin
        // The parent keeps its index and gains one child.
        st_we    = 1'b1;
        st_waddr = pos_r[AW-1:0];
        st_wdata = {par_r[NW-1:0], exp_r + NW'(1)};
      end
      ST_WR_TOP: begin
        st_we = 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        err_nxt = err_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      err_r       <= STAT_OK;
      level_r     <= '0;
      roots_r     <= '0;
      next_r      <= '0;
      ann_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      level_r     <= level_nxt;
      roots_r     <= roots_nxt;
      next_r      <= next_nxt;
      ann_r       <= ann_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    dep_r <= dep_nxt;
    exp_r <= exp_nxt;
    if (accept) begin
      idx_r  <= in_node_index;
      par_r  <= in_parent_ref;
      sib_r  <= in_sibling_pos;
      smax_r <= in_shots_max;
      snow_r <= in_shots_now;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_status_r <= err_r;
      out_depth_r  <= 5'(dep_r);
      out_done_r   <= (err_r == STAT_OK) && (next_r == ann_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_node_depth  = out_depth_r;
  assign out_record_done = out_done_r;

endmodule

/* design/pfsv_checker.sv */
// Port-level checker of the preorder forest validator and its bind to the top level.
`include "preorder_forest_stream_validator_defines.svh"

module pfsv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [4:0] out_node_depth,
  input logic       out_record_done
);
  import pfsv_pkg::*;

  logic out_stall;
  logic out_err;

  assign out_stall = out_valid && !out_ready;
  assign out_err   = out_valid && (out_status != STAT_OK);

  // A stalled result word must hold its status.
  `PFSV_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_status), "word changed")

  // Only one word is worked on at a time.
  `PFSV_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while busy")

  // A complete record never carries an error.
  `PFSV_ASSERT_NOW(a_done_ok, out_valid && out_record_done, out_status == STAT_OK, "done on error")

  // A word that reports an error never reports a depth.
  `PFSV_ASSERT_NOW(a_err_no_depth, out_err, out_node_depth == 5'd0, "depth with error")

endmodule

bind preorder_forest_stream_validator pfsv_checker u_pfsv_checker (.*);

/* test/tb_top.sv */
// Self-checking testbench for the preorder forest stream validator.
`timescale 1ns / 1ps

module tb_top;
  import pfsv_pkg::*;

  localparam int unsigned NODE_LIMIT  = MAX_NODES_DEF;
  localparam int unsigned DEPTH_LIMIT = MAX_DEPTH_DEF;
  localparam int unsigned WORD_TARGET = 1400;
  // A correct block never goes this long without moving a word on either side.
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] depth;
    logic       done;
  } forest_result_t;

  // Ways in which a node word built from a legal tree is spoiled on purpose.
  typedef enum int {
    BAD_INDEX,
    BAD_SIBLING,
    PARENT_AHEAD,
    PARENT_GUESS,
    SHOT_OVER
  } spoil_kind_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_func;
  logic [31:0]        in_node_count;
  logic [31:0]        in_node_index;
  logic [31:0]        in_parent_ref;
  logic [31:0]        in_sibling_pos;
  logic signed [15:0] in_shots_max;
  logic signed [15:0] in_shots_now;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [4:0]         out_node_depth;
  logic               out_record_done;

  preorder_forest_stream_validator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_node_count  (in_node_count),
    .in_node_index  (in_node_index),
    .in_parent_ref  (in_parent_ref),
    .in_sibling_pos (in_sibling_pos),
    .in_shots_max   (in_shots_max),
    .in_shots_now   (in_shots_now),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_node_depth (out_node_depth),
    .out_record_done(out_record_done)
  );

  // Free-running 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the validator state. It is advanced once per accepted
  // input word, so at any time it describes the block as it will be after
  // all accepted words have been worked on. The stimulus generator reads it
  // to grow legal trees.
  logic [31:0]    anc_node [DEPTH_LIMIT];
  logic [31:0]    anc_kids [DEPTH_LIMIT];
  int unsigned    anc_level;
  int unsigned    root_seen;
  int unsigned    next_idx;
  int unsigned    announced;
  logic [1:0]     sticky_err;

  // Results predicted but not yet seen on the output channel, oldest first.
  forest_result_t pending_results[$];

  int unsigned    fail_count;
  int unsigned    word_count;
  int unsigned    checked_count;
  int unsigned    record_count;
  int unsigned    invalid_hits;
  int unsigned    depth_hits;
  int unsigned    deepest;
  int unsigned    quiet_cycles = 0;
  bit             calm;

  // Works out the result of one word and advances the shadow state. Checks
  // run in the block's order: index, parent, sibling, depth, then shots.
  function automatic forest_result_t forest_predict(
    input logic               func,
    input logic [31:0]        cnt,
    input logic [31:0]        idx,
    input logic [31:0]        par,
    input logic [31:0]        sib,
    input logic signed [15:0] smax,
    input logic signed [15:0] snow
  );
    forest_result_t r;
    logic [1:0]     code;
    logic [31:0]    want;
    int unsigned    pos;
    int unsigned    depth;
    code  = STAT_OK;
    want  = '0;
    pos   = 0;
    depth = 0;
    if (func == FUNC_HEADER) begin
      sticky_err = STAT_OK;
      anc_level  = 0;
      root_seen  = 0;
      next_idx   = 0;
      if (cnt > NODE_LIMIT) begin
        sticky_err = STAT_INVALID;
        announced  = 0;
      end else begin
        announced = cnt;
      end
    end else if (sticky_err != STAT_OK) begin
      // A node after an error is dropped and reports nothing new.
      r.status = sticky_err;
      r.depth  = '0;
      r.done   = 1'b0;
      return r;
    end else begin
      if (next_idx >= announced || idx != next_idx) begin
        code = STAT_INVALID;
      end else if (par == ROOT_MARK) begin
        want  = root_seen;
        depth = 1;
      end else if (par >= idx) begin
        code = STAT_INVALID;
      end else begin
        while (pos < anc_level && anc_node[pos] != par) pos++;
        if (pos >= anc_level) begin
          code = STAT_INVALID;
        end else begin
          want  = anc_kids[pos];
          depth = pos + 2;
        end
      end
      if (code == STAT_OK) begin
        if (sib != want) code = STAT_INVALID;
        else if (depth > DEPTH_LIMIT) code = STAT_DEPTH;
        else if (snow > smax) code = STAT_INVALID;
      end
      if (code != STAT_OK) begin
        sticky_err = code;
        depth      = 0;
      end else begin
        if (par == ROOT_MARK) root_seen++;
        else anc_kids[pos] = anc_kids[pos] + 1;
        anc_level           = depth - 1;
        anc_node[anc_level] = idx;
        anc_kids[anc_level] = '0;
        anc_level++;
        next_idx++;
      end
    end
    r.status = sticky_err;
    r.depth  = depth[4:0];
    r.done   = (sticky_err == STAT_OK && next_idx == announced);
    return r;
  endfunction

  // Presents one word, holds it until it is taken, then records the
  // predicted result. in_valid is left high after the accept so that a
  // following word can go out back to back; every pause lowers it first.
  task automatic send_word(
    input logic               func,
    input logic [31:0]        cnt,
    input logic [31:0]        idx,
    input logic [31:0]        par,
    input logic [31:0]        sib,
    input logic signed [15:0] smax,
    input logic signed [15:0] snow
  );
    logic [1:0]     err_before;
    forest_result_t r;
    if (!calm) begin
      while ($urandom_range(99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_node_count  <= cnt;
    in_node_index  <= idx;
    in_parent_ref  <= par;
    in_sibling_pos <= sib;
    in_shots_max   <= smax;
    in_shots_now   <= snow;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    err_before = sticky_err;
    r = forest_predict(func, cnt, idx, par, sib, smax, snow);
    pending_results.push_back(r);
    // Words that the block merely drops do not count toward the target.
    if (func == FUNC_HEADER || err_before == STAT_OK) word_count++;
    if (func == FUNC_HEADER) record_count++;
    if (func == FUNC_NODE && err_before == STAT_OK) begin
      if (r.status == STAT_INVALID) invalid_hits++;
      if (r.status == STAT_DEPTH) depth_hits++;
      if (r.depth > deepest) deepest = 32'(r.depth);
    end
  endtask

  task automatic send_header(input logic [31:0] cnt);
    send_word(FUNC_HEADER, cnt, $urandom, $urandom, $urandom, 16'($urandom),
              16'($urandom));
  endtask

  task automatic send_node(
    input logic [31:0]        idx,
    input logic [31:0]        par,
    input logic [31:0]        sib,
    input logic signed [15:0] smax,
    input logic signed [15:0] snow
  );
    send_word(FUNC_NODE, $urandom, idx, par, sib, smax, snow);
  endtask

  // Holds the sender off until every predicted result has come back.
  // It always lowers in_valid and waits for the clock before it returns, so
  // that in_valid is never lowered and raised in the same step.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Builds the next node of a legal preorder forest from the shadow state,
  // and sometimes spoils one field of it.
  task automatic send_grown_node(input int spoil_pct, input int deep_pct);
    logic [31:0]        idx;
    logic [31:0]        par;
    logic [31:0]        sib;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] smax;
    logic signed [15:0] snow;
    int                 p;
    int                 root_pct;
    idx      = next_idx;
    root_pct = (deep_pct > 50) ? 2 : 12;
    if (anc_level == 0 || $urandom_range(99) < root_pct) begin
      par = ROOT_MARK;
      sib = root_seen;
    end else begin
      // Deepening keeps hanging nodes under the newest one, which walks the
      // whole stack and eventually runs into the depth limit.
      if ($urandom_range(99) < deep_pct) p = anc_level - 1;
      else p = $urandom_range(anc_level - 1, 0);
      par = anc_node[p];
      sib = anc_kids[p];
    end
    a = 16'($urandom);
    b = 16'($urandom);
    if ($urandom_range(9) == 0) b = a;
    if (a >= b) begin
      smax = a;
      snow = b;
    end else begin
      smax = b;
      snow = a;
    end
    if ($urandom_range(99) < spoil_pct) begin
      case (spoil_kind_t'($urandom_range(SHOT_OVER, BAD_INDEX)))
        BAD_INDEX: begin
          if ($urandom_range(1) == 0) idx = idx + $urandom_range(3, 1);
          else idx = $urandom;
        end
        BAD_SIBLING: begin
          sib = sib + $urandom_range(2, 1);
        end
        PARENT_AHEAD: begin
          par = idx + $urandom_range(3, 0);
        end
        PARENT_GUESS: begin
          // Any earlier index; it may or may not still be an ancestor.
          if (idx != 0) par = $urandom_range(idx - 1, 0);
        end
        default: begin
          if (smax == 16'sh7FFF) begin
            smax = 16'sh7FFE;
            snow = 16'sh7FFF;
          end else begin
            snow = smax + 16'sd1;
          end
        end
      endcase
    end
    send_node(idx, par, sib, smax, snow);
  endtask

  // Any word at all, with every field drawn over its full width.
  task automatic send_noise();
    send_word(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
              16'($urandom), 16'($urandom));
  endtask

  // A node before any header finds nothing announced and is rejected; the
  // word after it is dropped.
  task automatic test_reset_state();
    send_node(32'd0, ROOT_MARK, 32'd0, 16'sd5, 16'sd1);
    send_node(32'd0, ROOT_MARK, 32'd0, 16'sd5, 16'sd1);
  endtask

  // Headers at and beyond the node limit, including the all-ones count.
  task automatic test_header_counts();
    send_header(NODE_LIMIT);
    send_header(NODE_LIMIT + 1);
    send_node(32'd0, ROOT_MARK, 32'd0, 16'sd0, 16'sd0);
    send_header(32'hFFFF_FFFF);
  endtask

  // A complete small forest with two roots, ending in record_done, and the
  // shot counts at their extremes.
  task automatic test_small_forest();
    send_header(32'd4);
    send_node(32'd0, ROOT_MARK, 32'd0, 16'sh7FFF, 16'sh8000);
    send_node(32'd1, 32'd0, 32'd0, 16'sh8000, 16'sh8000);
    send_node(32'd2, 32'd0, 32'd1, 16'sd0, 16'sd0);
    send_node(32'd3, ROOT_MARK, 32'd1, 16'sh7FFF, 16'sh7FFF);
  endtask

  // One record per kind of structural error.
  task automatic test_node_errors();
    // Parent that was popped off the ancestor stack by a later root.
    send_header(32'd3);
    send_node(32'd0, ROOT_MARK, 32'd0, 16'sd1, 16'sd0);
    send_node(32'd1, ROOT_MARK, 32'd1, 16'sd1, 16'sd0);
    send_node(32'd2, 32'd0, 32'd0, 16'sd1, 16'sd0);
    // Parent equal to the node's own index.
    send_header(32'd2);
    send_node(32'd0, ROOT_MARK, 32'd0, 16'sd1, 16'sd0);
    send_node(32'd1, 32'd1, 32'd0, 16'sd1, 16'sd0);
    // Node that skips an index.
    send_header(32'd1);
    send_node(32'd1, ROOT_MARK, 32'd0, 16'sd1, 16'sd0);
    // Root with the wrong sibling number.
    send_header(32'd1);
    send_node(32'd0, ROOT_MARK, 32'd1, 16'sd1, 16'sd0);
    // Current shot count above the maximum.
    send_header(32'd1);
    send_node(32'd0, ROOT_MARK, 32'd0, 16'sd0, 16'sd1);
    // Empty record is done at once; a node after it is beyond the count.
    send_header(32'd0);
    send_node(32'd0, ROOT_MARK, 32'd0, 16'sd1, 16'sd0);
  endtask

  // A single chain that fills the ancestor stack, then one level more.
  task automatic test_depth_limit();
    int unsigned i;
    send_header(DEPTH_LIMIT + 1);
    send_node(32'd0, ROOT_MARK, 32'd0, 16'sd3, 16'sd2);
    for (i = 1; i <= DEPTH_LIMIT; i++) send_node(i, i - 1, 32'd0, 16'sd3, 16'sd2);
  endtask

  // Mostly legal records of random shape with occasional spoiled fields,
  // noise words, short and overlong records, and now and then a pause
  // until the block has drained.
  task automatic test_random_records();
    int unsigned rec;
    int unsigned cnt;
    int unsigned nodes;
    int unsigned k;
    int unsigned dropped;
    int unsigned pick;
    bit          deep;
    rec = 0;
    while (word_count < WORD_TARGET) begin
      calm = (rec >= 20 && rec < 36);
      if (rec % 10 == 9) wait_for_drain();
      deep = ($urandom_range(7) == 0);
      pick = $urandom_range(99);
      if (pick < 5) cnt = 0;
      else if (pick < 10) cnt = $urandom;
      else if (pick < 15) cnt = $urandom_range(200, 60);
      else if (deep) cnt = $urandom_range(60, 30);
      else cnt = $urandom_range(30, 1);
      nodes = (cnt > 200) ? $urandom_range(2, 0) : cnt;
      pick = $urandom_range(99);
      if (pick < 8) nodes = $urandom_range(nodes, 0);
      else if (pick < 16) nodes = nodes + $urandom_range(2, 1);
      send_header(cnt);
      dropped = 0;
      for (k = 0; k < nodes; k++) begin
        if (sticky_err != STAT_OK) begin
          if (dropped >= 2) break;
          dropped++;
        end
        if ($urandom_range(99) < 3) send_noise();
        else send_grown_node(deep ? 1 : 3, deep ? 95 : 30);
      end
      rec++;
    end
    calm = 1'b0;
  endtask

  // Result checker: compares every accepted result word with the oldest
  // prediction, field by field, and draws the receiver's stalls.
  always @(posedge clk) begin
    forest_result_t want;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting: status %0d depth %0d done %0d",
               out_status, out_node_depth, out_record_done);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_node_depth !== want.depth) begin
          $error("node_depth mismatch: expected %0d, got %0d", want.depth, out_node_depth);
          fail_count++;
        end
        if (out_record_done !== want.done) begin
          $error("record_done mismatch: expected %0d, got %0d", want.done,
                 out_record_done);
          fail_count++;
        end
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 26);
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles.", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    fail_count     = 0;
    word_count     = 0;
    checked_count  = 0;
    record_count   = 0;
    invalid_hits   = 0;
    depth_hits     = 0;
    deepest        = 0;
    calm           = 1'b0;
    anc_level      = 0;
    root_seen      = 0;
    next_idx       = 0;
    announced      = 0;
    sticky_err     = STAT_OK;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_HEADER;
    in_node_count  <= '0;
    in_node_index  <= '0;
    in_parent_ref  <= '0;
    in_sibling_pos <= '0;
    in_shots_max   <= '0;
    in_shots_now   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_header_counts();
    test_small_forest();
    test_node_errors();
    test_depth_limit();
    test_random_records();

    // Let the last results come out, then give the block time to show any
    // result word that it should not produce.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d counted words over %0d records; %0d results compared.",
             word_count, record_count, checked_count);
    $display("Nodes rejected as invalid: %0d, over the depth limit: %0d, deepest kept: %0d.",
             invalid_hits, depth_hits, deepest);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
